// ===== sv/smg_pkg.sv =====
`default_nettype none

package smg_pkg;

   // Four channels per sample: x, y, z and field magnitude, in that order.
   localparam int CHANNELS = 4;
   localparam int GROUP_BITS = 10;
   localparam int USED_BITS = 8;

endpackage

`default_nettype wire

// ===== sv/smg_front.sv =====
`default_nettype none

module smg_front
   import smg_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int MAX_SAMPLES = 128,
   parameter int GROUP_SPAN = 1024,
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_SAMPLES) + 3,
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
   localparam int JOB_W = GROUP_BITS + CHANNELS * SUM_W + CNT_W
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      in_valid,
   output logic                                           in_ready,
   input  wire logic [GROUP_BITS-1:0]                     group_id,
   input  wire logic [CHANNELS-1:0][SAMPLE_BITS-1:0]      sample,
   input  wire logic                                      last,
   output logic                                           push_valid,
   input  wire logic                                      push_ready,
   output logic [JOB_W-1:0]                               push_job
);

   logic signed [SAMPLE_BITS-1:0] older_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] older_in [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] newer_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0] newer_in [CHANNELS];
   logic signed [SUM_W-1:0]       sum_ff [CHANNELS];
   logic signed [SUM_W-1:0]       sum_in [CHANNELS];
   logic signed [SUM_W-1:0]       sum_next [CHANNELS];
   logic signed [SUM_W-1:0]       x_ext;
   logic signed [SUM_W-1:0]       mid_term;
   logic [CNT_W-1:0]              kept_ff;
   logic [CNT_W-1:0]              kept_in;
   logic                          keep;
   logic                          run_end;
   logic                          in_span;
   logic                          take;

   assign in_ready = push_ready;

   always_comb begin
      keep = kept_ff < CNT_W'(MAX_SAMPLES);
      // The sample that fills the run to the cap closes the smoothed run.
      run_end = last || (kept_ff == CNT_W'(MAX_SAMPLES - 1));
      in_span = 32'(group_id) < 32'(GROUP_SPAN);
      take = in_valid && in_ready && in_span;
      push_valid = take && last;

      kept_in = kept_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         x_ext = SUM_W'($signed(sample[c]));
         mid_term = SUM_W'(older_ff[c]) + (SUM_W'(newer_ff[c]) <<< 1) + x_ext;
         sum_next[c] = sum_ff[c];
         if (kept_ff >= CNT_W'(2)) begin
            sum_next[c] = sum_next[c] + mid_term;
         end
         if ((kept_ff == '0) || run_end) begin
            sum_next[c] = sum_next[c] + (x_ext <<< 2);
         end
         older_in[c] = older_ff[c];
         newer_in[c] = newer_ff[c];
         sum_in[c] = sum_ff[c];
      end

      push_job = '0;
      push_job[GROUP_BITS-1:0] = group_id;
      for (int c = 0; c < CHANNELS; c++) begin
         push_job[GROUP_BITS + c * SUM_W +: SUM_W] = keep ? sum_next[c] : sum_ff[c];
      end
      push_job[JOB_W-1 -: CNT_W] = keep ? kept_ff + CNT_W'(1) : kept_ff;

      if (take) begin
         if (keep) begin
            for (int c = 0; c < CHANNELS; c++) begin
               older_in[c] = newer_ff[c];
               newer_in[c] = $signed(sample[c]);
               sum_in[c] = sum_next[c];
            end
            kept_in = kept_ff + CNT_W'(1);
         end
         if (last) begin
            for (int c = 0; c < CHANNELS; c++) begin
               older_in[c] = '0;
               newer_in[c] = '0;
               sum_in[c] = '0;
            end
            kept_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            older_ff[c] <= '0;
            newer_ff[c] <= '0;
            sum_ff[c] <= '0;
         end
         kept_ff <= '0;
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            older_ff[c] <= older_in[c];
            newer_ff[c] <= newer_in[c];
            sum_ff[c] <= sum_in[c];
         end
         kept_ff <= kept_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/smg_queue.sv =====
`default_nettype none

module smg_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = fill_ff != FILL_W'(DEPTH);
   assign pop_valid = fill_ff != '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      do_push = push_valid && push_ready;
      do_pop = pop_valid && pop_ready;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      fill_in = fill_ff + FILL_W'(do_push) - FILL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/smg_mean_div.sv =====
`default_nettype none

module smg_mean_div
   import smg_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   parameter int MAX_SAMPLES = 128,
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_SAMPLES) + 3,
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1),
   localparam int JOB_W = GROUP_BITS + CHANNELS * SUM_W + CNT_W
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 job_valid,
   output logic                                      job_ready,
   input  wire logic [JOB_W-1:0]                     job,
   output logic                                      out_valid,
   input  wire logic                                 out_ready,
   output logic [GROUP_BITS-1:0]                     out_group,
   output logic [CHANNELS-1:0][SAMPLE_BITS-1:0]      out_mean,
   output logic [USED_BITS-1:0]                      out_used
);

   localparam int DEN_W = CNT_W + 2;
   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [1:0] {
      IDLE,
      RUN,
      DONE
   } state_type;

   state_type                  state_ff;
   state_type                  state_in;
   logic [GROUP_BITS-1:0]      gid_ff;
   logic [GROUP_BITS-1:0]      gid_in;
   logic [CNT_W-1:0]           cnt_ff;
   logic [CNT_W-1:0]           cnt_in;
   logic [STEP_W-1:0]          step_ff;
   logic [STEP_W-1:0]          step_in;
   logic [CHANNELS-1:0]        neg_ff;
   logic [CHANNELS-1:0]        neg_in;
   // Each quotient register starts as the dividend and shifts quotient bits in.
   logic [SUM_W-1:0]           quo_ff [CHANNELS];
   logic [SUM_W-1:0]           quo_in [CHANNELS];
   logic [DEN_W-1:0]           rem_ff [CHANNELS];
   logic [DEN_W-1:0]           rem_in [CHANNELS];
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic [GROUP_BITS-1:0]      out_group_ff;
   logic [GROUP_BITS-1:0]      out_group_in;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] out_mean_ff;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] out_mean_in;
   logic [USED_BITS-1:0]       out_used_ff;
   logic [USED_BITS-1:0]       out_used_in;
   logic [DEN_W-1:0]           den;
   logic [DEN_W:0]             shifted;
   logic                       ge;
   logic [SUM_W-1:0]           job_sum;
   logic [SUM_W-1:0]           mag;
   logic [SUM_W-1:0]           signed_quo;
   logic [CNT_W-1:0]           job_cnt;
   logic                       out_free;

   assign job_ready = state_ff == IDLE;
   assign out_valid = out_valid_ff;
   assign out_group = out_group_ff;
   assign out_mean = out_mean_ff;
   assign out_used = out_used_ff;

   always_comb begin
      state_in = state_ff;
      gid_in = gid_ff;
      cnt_in = cnt_ff;
      step_in = step_ff;
      neg_in = neg_ff;
      out_group_in = out_group_ff;
      out_mean_in = out_mean_ff;
      out_used_in = out_used_ff;
      out_free = !out_valid_ff || out_ready;
      out_valid_in = out_valid_ff && !out_ready;
      den = {cnt_ff, 2'b00};
      job_cnt = job[JOB_W-1 -: CNT_W];
      shifted = '0;
      ge = 1'b0;
      job_sum = '0;
      mag = '0;
      signed_quo = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         quo_in[c] = quo_ff[c];
         rem_in[c] = rem_ff[c];
      end

      case (state_ff)
         IDLE: begin
            if (job_valid) begin
               gid_in = job[GROUP_BITS-1:0];
               cnt_in = job_cnt;
               step_in = '0;
               for (int c = 0; c < CHANNELS; c++) begin
                  job_sum = job[GROUP_BITS + c * SUM_W +: SUM_W];
                  neg_in[c] = job_sum[SUM_W-1];
                  mag = job_sum[SUM_W-1] ? -job_sum : job_sum;
                  // Adding half the divisor makes the truncating divide round
                  // to nearest, ties away from zero once the sign goes back on.
                  quo_in[c] = mag + SUM_W'({job_cnt, 1'b0});
                  rem_in[c] = '0;
               end
               state_in = RUN;
            end
         end
         RUN: begin
            for (int c = 0; c < CHANNELS; c++) begin
               shifted = {rem_ff[c], quo_ff[c][SUM_W-1]};
               ge = shifted >= (DEN_W + 1)'(den);
               rem_in[c] = ge ? DEN_W'(shifted - (DEN_W + 1)'(den)) : DEN_W'(shifted);
               quo_in[c] = {quo_ff[c][SUM_W-2:0], ge};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = DONE;
            end
         end
         DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_group_in = gid_ff;
               out_used_in = USED_BITS'(cnt_ff);
               for (int c = 0; c < CHANNELS; c++) begin
                  signed_quo = neg_ff[c] ? -quo_ff[c] : quo_ff[c];
                  out_mean_in[c] = signed_quo[SAMPLE_BITS-1:0];
               end
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         out_valid_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff <= step_in;
      end
      gid_ff <= gid_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      out_group_ff <= out_group_in;
      out_mean_ff <= out_mean_in;
      out_used_ff <= out_used_in;
      for (int c = 0; c < CHANNELS; c++) begin
         quo_ff[c] <= quo_in[c];
         rem_ff[c] <= rem_in[c];
      end
   end

endmodule

`default_nettype wire

// ===== sv/smoothed_group_mean.sv =====
`default_nettype none

// Smoothed group mean: takes one magnetometer sample (x, y, z, magnitude)
// per beat, smooths every channel with a 1/4, 1/2, 1/4 kernel (the first and
// last sample of a run pass through unchanged) and, on the beat marked tlast,
// returns the rounded mean of each smoothed channel with the sample count.
// Samples past MAX_SAMPLES in a run are dropped; samples whose group id is
// not below GROUP_SPAN are ignored. The front accepts one sample every cycle
// while the queue has room. Each finished run is handed through a two-entry
// queue to a shift-subtract divider that produces one quotient bit per cycle
// for all four channels at once, working through all SUM_W bits of the sums
// (SUM_W = SAMPLE_BITS + clog2(MAX_SAMPLES) + 3). When the queue is full,
// req_tready drops until the divider frees an entry.

module smoothed_group_mean
   import smg_pkg::*;
#(
   parameter int MAX_SAMPLES = 128,
   parameter int GROUP_SPAN = 1024,
   parameter int SAMPLE_BITS = 24,
   localparam int REQ_W = ((GROUP_BITS + CHANNELS * SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((GROUP_BITS + CHANNELS * SAMPLE_BITS + USED_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // group_id, x_sample, y_sample, z_sample, mag_sample, zero fill
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             req_tlast,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // group_out, x_mean, y_mean, z_mean, mag_mean, used_count, zero fill
   output logic [RSP_W-1:0]      rsp_tdata
);

   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_SAMPLES) + 3;
   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int JOB_W = GROUP_BITS + CHANNELS * SUM_W + CNT_W;
   localparam int MEAN_LO = GROUP_BITS;
   localparam int USED_LO = GROUP_BITS + CHANNELS * SAMPLE_BITS;

   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample;
   logic [CHANNELS-1:0][SAMPLE_BITS-1:0] mean;
   logic [GROUP_BITS-1:0]                group_out;
   logic [USED_BITS-1:0]                 used_count;
   logic                                 push_valid;
   logic                                 push_ready;
   logic [JOB_W-1:0]                     push_job;
   logic                                 pop_valid;
   logic                                 pop_ready;
   logic [JOB_W-1:0]                     pop_job;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         sample[c] = req_tdata[MEAN_LO + c * SAMPLE_BITS +: SAMPLE_BITS];
      end
      rsp_tdata = '0;
      rsp_tdata[GROUP_BITS-1:0] = group_out;
      for (int c = 0; c < CHANNELS; c++) begin
         rsp_tdata[MEAN_LO + c * SAMPLE_BITS +: SAMPLE_BITS] = mean[c];
      end
      rsp_tdata[USED_LO +: USED_BITS] = used_count;
   end

   smg_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SAMPLES (MAX_SAMPLES),
      .GROUP_SPAN  (GROUP_SPAN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .group_id   (req_tdata[GROUP_BITS-1:0]),
      .sample     (sample),
      .last       (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   smg_queue #(
      .WIDTH (JOB_W),
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_job)
   );

   smg_mean_div #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job       (pop_job),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_group (group_out),
      .out_mean  (mean),
      .out_used  (used_count)
   );

endmodule

`default_nettype wire

// ===== sv/smg_checker.sv =====
`default_nettype none

module smg_checker
   import smg_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   localparam int RSP_W = ((GROUP_BITS + CHANNELS * SAMPLE_BITS + USED_BITS + 7) / 8) * 8,
   localparam int USED_LO = GROUP_BITS + CHANNELS * SAMPLE_BITS
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [RSP_W-1:0] rsp_tdata
);

   // A result beat that is not taken stays offered.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat withdrawn before it was taken");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // Every reported run keeps at least its first sample.
   a_used_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[USED_LO +: USED_BITS] != '0)
      else $error("result reports an empty run");

   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

endmodule

bind smoothed_group_mean smg_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_smg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/group_mean_checker.sv =====
`timescale 1ns / 1ps

module group_mean_checker
   import smg_pkg::*;
#(
   parameter int MAX_SAMPLES = 128,
   parameter int GROUP_SPAN = 1024,
   parameter int SAMPLE_BITS = 24,
   localparam int REQ_W = ((GROUP_BITS + CHANNELS * SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((GROUP_BITS + CHANNELS * SAMPLE_BITS + USED_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   // group_id, x_sample, y_sample, z_sample, mag_sample, zero fill
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic             req_tlast,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   // group_out, x_mean, y_mean, z_mean, mag_mean, used_count, zero fill
   input  wire logic [RSP_W-1:0] rsp_tdata,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      logic [REQ_W-GROUP_BITS-CHANNELS*SAMPLE_BITS-1:0] fill;
      logic [CHANNELS-1:0][SAMPLE_BITS-1:0]             sample;
      logic [GROUP_BITS-1:0]                            group;
   } sample_beat_type;

   typedef struct packed {
      logic [RSP_W-GROUP_BITS-CHANNELS*SAMPLE_BITS-USED_BITS-1:0] fill;
      logic [USED_BITS-1:0]                                       used;
      logic [CHANNELS-1:0][SAMPLE_BITS-1:0]                       mean;
      logic [GROUP_BITS-1:0]                                      group;
   } mean_beat_type;

   // Running state of the current group, values held at full precision.
   longint        older_value [CHANNELS];
   longint        newer_value [CHANNELS];
   longint        quarter_total [CHANNELS];
   int            kept;
   mean_beat_type expected_means [$];

   function automatic logic [SAMPLE_BITS-1:0] rounded_mean(input longint total, input int count);
      longint den;
      longint mag;
      longint q;
      den = 4 * longint'(count);
      mag = (total < 0) ? -total : total;
      q = (mag + den / 2) / den;
      if (total < 0) begin
         q = -q;
      end
      return q[SAMPLE_BITS-1:0];
   endfunction

   task automatic clear_run();
      int c;
      for (c = 0; c < CHANNELS; c++) begin
         older_value[c] = 0;
         newer_value[c] = 0;
         quarter_total[c] = 0;
      end
      kept = 0;
   endtask

   task automatic take_sample(input sample_beat_type beat, input logic last);
      logic          run_end;
      longint        value;
      mean_beat_type result;
      int            c;
      if (int'(beat.group) < GROUP_SPAN) begin
         if (kept < MAX_SAMPLES) begin
            // The sample that fills the cap closes the smoothed run like a last one.
            run_end = last || kept == MAX_SAMPLES - 1;
            for (c = 0; c < CHANNELS; c++) begin
               value = longint'($signed(beat.sample[c]));
               if (kept >= 2) begin
                  quarter_total[c] += older_value[c] + 2 * newer_value[c] + value;
               end
               if (kept == 0 || run_end) begin
                  quarter_total[c] += 4 * value;
               end
               older_value[c] = newer_value[c];
               newer_value[c] = value;
            end
            kept++;
         end
         if (last) begin
            result = '0;
            result.group = beat.group;
            for (c = 0; c < CHANNELS; c++) begin
               result.mean[c] = rounded_mean(quarter_total[c], kept);
            end
            result.used = USED_BITS'(kept);
            expected_means.push_back(result);
            clear_run();
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
      end
   endtask

   task automatic check_result(input mean_beat_type got);
      mean_beat_type want;
      string         names [CHANNELS];
      int            c;
      names = '{"x_mean", "y_mean", "z_mean", "mag_mean"};
      if (expected_means.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: result beat with none expected: %h", $realtime, got);
         end
      end else begin
         want = expected_means.pop_front();
         if (got.group !== want.group) begin
            report_mismatch("group_out", 32'(want.group), 32'(got.group));
         end
         for (c = 0; c < CHANNELS; c++) begin
            if (got.mean[c] !== want.mean[c]) begin
               report_mismatch(names[c], 32'(want.mean[c]), 32'(got.mean[c]));
            end
         end
         if (got.used !== want.used) begin
            report_mismatch("used_count", 32'(want.used), 32'(got.used));
         end
      end
   endtask

   // A result beat can never stem from the sample taken at the same edge,
   // so results are checked before the new sample is folded in.
   always @(posedge clock) begin
      if (reset) begin
         expected_means.delete();
         clear_run();
         outstanding = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_result(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            take_sample(req_tdata, req_tlast);
         end
         outstanding = expected_means.size();
      end
   end

endmodule

// ===== tb/smoothed_group_mean_test.sv =====
`timescale 1ns / 1ps

module smoothed_group_mean_test;
   import smg_pkg::*;

   localparam int MAX_SAMPLES = 128;
   localparam int GROUP_SPAN = 1024;
   localparam int SAMPLE_BITS = 24;
   localparam int REQ_W = ((GROUP_BITS + CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((GROUP_BITS + CHANNELS * SAMPLE_BITS + USED_BITS + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [SAMPLE_BITS-1:0] MOST = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] LEAST = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   int               mismatches;
   int               outstanding;
   bit               idle_on;
   bit               stall_on;
   int               samples_sent;
   int               runs_sent;
   int               cycles;

   smoothed_group_mean #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .GROUP_SPAN(GROUP_SPAN),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   group_mean_checker #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .GROUP_SPAN(GROUP_SPAN),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) mean_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .mismatches(mismatches),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: random stall bursts while stall_on is set.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [CHANNELS-1:0][SAMPLE_BITS-1:0] four_channels(
      input logic [SAMPLE_BITS-1:0] x, y, z, m);
      return {m, z, y, x};
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_value();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return SAMPLE_BITS'($urandom);
         4, 5: return SAMPLE_BITS'($urandom_range(0, 1023) - 512);
         6: return ($urandom_range(0, 1) == 0) ? MOST : LEAST;
         default: return ($urandom_range(0, 1) == 0) ? '0 : '1;
      endcase
   endfunction

   // Mostly short runs, some medium, and a few that run into the sample cap.
   function automatic int run_length();
      case ($urandom_range(0, 19))
         0: return $urandom_range(120, 135);
         1, 2, 3, 4: return $urandom_range(9, 40);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   // Leaves tvalid high after the beat so back-to-back beats need no gap.
   task automatic send_sample(input logic [GROUP_BITS-1:0] group,
                              input logic [CHANNELS-1:0][SAMPLE_BITS-1:0] values,
                              input logic last);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_W'({values, group});
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic send_run(input int length);
      logic [GROUP_BITS-1:0]                group;
      logic [CHANNELS-1:0][SAMPLE_BITS-1:0] values;
      int                                   i;
      int                                   c;
      group = GROUP_BITS'($urandom);
      for (i = 0; i < length; i++) begin
         // The group id may change inside a run; only the last one is reported.
         if ($urandom_range(0, 19) == 0) begin
            group = GROUP_BITS'($urandom);
         end
         for (c = 0; c < CHANNELS; c++) begin
            values[c] = random_value();
         end
         send_sample(group, values, i == length - 1);
      end
      runs_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;
      wait (outstanding == 0);
   endtask

   initial begin
      int i;
      int c;
      logic [CHANNELS-1:0][SAMPLE_BITS-1:0] values;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      idle_on = 1'b1;
      stall_on = 1'b1;
      samples_sent = 0;
      runs_sent = 0;
      cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single-sample runs at the extremes of every field.
      send_sample('0, four_channels(MOST, MOST, MOST, MOST), 1'b1);
      send_sample('1, four_channels(LEAST, LEAST, LEAST, LEAST), 1'b1);
      // Two-sample run passes through whole.
      send_sample(10'h2AA, four_channels(MOST, LEAST, '0, '1), 1'b0);
      send_sample(10'h155, four_channels(LEAST, MOST, '1, '0), 1'b1);
      // Three samples whose means land exactly on halves, both signs.
      send_sample(10'd3, four_channels('0, '0, '0, '0), 1'b0);
      send_sample(10'd3, four_channels(24'd3, -24'sd3, 24'd9, -24'sd9), 1'b0);
      send_sample(10'd3, four_channels('0, '0, '0, '0), 1'b1);
      // Group id changes without a last beat in between.
      send_sample(10'd5, four_channels(24'd100, -24'sd100, MOST, 24'd1), 1'b0);
      send_sample(10'd6, four_channels(24'd7, 24'd8, LEAST, -24'sd1), 1'b0);
      send_sample(10'd7, four_channels(-24'sd55, 24'd1000, 24'd2, 24'd5), 1'b1);
      // Alternating extremes stress the sum width.
      for (i = 0; i < 4; i++) begin
         for (c = 0; c < CHANNELS; c++) begin
            values[c] = ((i + c) % 2 == 1) ? LEAST : MOST;
         end
         send_sample(10'd200, values, i == 3);
      end
      drain();

      // Runs that end exactly at the sample cap and just past it.
      send_run(MAX_SAMPLES);
      send_run(MAX_SAMPLES + 2);
      while (samples_sent < 600) begin
         idle_on = $urandom_range(0, 3) != 0;
         stall_on = $urandom_range(0, 3) != 0;
         send_run(run_length());
      end
      drain();

      idle_on = 1'b0;
      stall_on = 1'b0;
      while (samples_sent < 900 || runs_sent < 48) begin
         send_run(run_length());
      end
      drain();

      repeat (100) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/smg_pkg.sv
sv/smg_front.sv
sv/smg_queue.sv
sv/smg_mean_div.sv
sv/smoothed_group_mean.sv
sv/smg_checker.sv
tb/group_mean_checker.sv
tb/smoothed_group_mean_test.sv
